FILE: src/gea_pkg.sv
// Package for the generational entity allocator.
// Holds the sizes, request and status codes, and the channel structs.
// No dependencies.
package gea_pkg;

    localparam int SLOTS       = 1024;
    localparam int INIT_SLOTS  = 16;
    localparam int MASK_BITS   = 32;
    localparam int GEN_BITS    = 32;
    localparam int START_SLOTS = (INIT_SLOTS < SLOTS) ? INIT_SLOTS : SLOTS;

    localparam int IDX_W  = 10;
    localparam int POOL_W = $clog2(SLOTS + 1);

    localparam logic [1:0] REQ_CREATE  = 2'd0;
    localparam logic [1:0] REQ_DESTROY = 2'd1;
    localparam logic [1:0] REQ_SETMASK = 2'd2;
    localparam logic [1:0] REQ_QUERY   = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
    localparam logic [1:0] STAT_OOP       = 2'd2;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd3;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [POOL_W-1:0]    pool_t;
    typedef logic [GEN_BITS-1:0]  gen_t;
    typedef logic [MASK_BITS-1:0] mask_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [9:0]  slot_index;
        logic [31:0] handle_generation;
        logic [31:0] component_mask;
    } req_t;

    typedef struct packed {
        logic [9:0]  out_index;
        logic [31:0] out_generation;
        logic [31:0] out_mask;
        logic        is_valid;
        logic        is_alive;
        logic [1:0]  status;
    } rsp_t;

    typedef struct packed {
        gen_t  gen;
        mask_t mask;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
        idx_t push_data;
    } qctl_t;

    typedef struct packed {
        pool_t count;
        idx_t  head_data;
    } qstat_t;

endpackage

FILE: src/gea_slot_store.sv
// Slot store: generation and mask per slot in one synchronous RAM.
// Runs a clearing pass after reset. Depends on gea_pkg.
module gea_slot_store import gea_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  idx_t   rd_addr,
    output entry_t rd_data,
    input  logic   wr_en,
    input  idx_t   wr_addr,
    input  entry_t wr_data,
    output logic   clear_done
);

    entry_t mem [SLOTS];
    entry_t rd_data_reg;
    pool_t  clr_reg;
    pool_t  clr_next;
    logic   clearing;
    entry_t clr_entry;

    assign clearing   = (clr_reg != pool_t'(SLOTS));
    assign clear_done = !clearing;
    assign clr_next   = clr_reg + pool_t'(1);
    assign rd_data    = rd_data_reg;

    always_comb begin
        clr_entry.mask = '0;
        clr_entry.gen  = (clr_reg < pool_t'(START_SLOTS)) ? gen_t'(1) : gen_t'(0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (clearing) begin
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clearing) begin
            mem[clr_reg[IDX_W-1:0]] <= clr_entry;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

FILE: src/gea_recycle_fifo.sv
// Recycle queue: freed slot indexes, first freed first reused.
// Synchronous RAM with head, tail and count. Depends on gea_pkg.
module gea_recycle_fifo import gea_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  qctl_t  ctl,
    output qstat_t stat
);

    idx_t  mem [SLOTS];
    idx_t  head_reg;
    idx_t  head_next;
    idx_t  tail_reg;
    idx_t  tail_next;
    pool_t count_reg;
    pool_t count_next;
    idx_t  head_data_reg;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.pop) begin
            head_next  = (head_reg == idx_t'(SLOTS - 1)) ? '0 : head_reg + idx_t'(1);
            count_next = count_reg - pool_t'(1);
        end
        if (ctl.push) begin
            tail_next  = (tail_reg == idx_t'(SLOTS - 1)) ? '0 : tail_reg + idx_t'(1);
            count_next = count_reg + pool_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            mem[tail_reg] <= ctl.push_data;
        end
        head_data_reg <= mem[head_reg];
    end

    assign stat.count     = count_reg;
    assign stat.head_data = head_data_reg;

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.push |-> (count_reg < pool_t'(SLOTS)))
        else $error("push into full recycle queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.pop |-> (count_reg != '0))
        else $error("pop from empty recycle queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= pool_t'(SLOTS))
        else $error("recycle count beyond depth");

endmodule

FILE: src/generational_entity_allocator.sv
// Generational entity allocator, top level.
// Uses gea_pkg, gea_slot_store and gea_recycle_fifo.
//
// Usage:
//   s_valid/s_ready/s_data carry one request (create, destroy, set mask,
//   query); m_valid/m_ready/m_data carry exactly one response per request,
//   in request order.
//   Between transfer and response valid, each request passes the slot RAM
//   read (the recycle queue head is already registered) and then the step
//   that modifies, writes back and loads the output register. A new request
//   is taken in the cycle after the response is loaded, so no request is
//   taken before the previous one is written back: the accept, read and
//   write-back steps run one after another.
//   The output register frees the slot path: the next request is taken and
//   read while a response still waits. If the receiver stalls and the output
//   register is still full when the next response is ready, the block holds
//   that request in its write-back step until m_ready.
//   After aresetn deasserts, a clearing pass writes all 1024 slot entries,
//   one per cycle; s_ready stays low until that pass is done.
module generational_entity_allocator import gea_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADDR = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    req_t   req_reg;
    pool_t  pool_reg;
    pool_t  pool_next;
    pool_t  fresh_reg;
    pool_t  fresh_next;

    idx_t   slot_reg;
    pool_t  pool_eff_reg;
    logic   exhausted_reg;
    logic   use_fresh_reg;
    logic   oop_reg;

    idx_t   slot_sel;
    pool_t  pool_eff;
    pool_t  grown;
    logic   need_grow;
    logic   exhausted;
    logic   use_fresh;
    logic   oop;

    logic   m_valid_reg;
    rsp_t   m_data_reg;
    rsp_t   rsp;
    logic   commit;
    logic   clear_done;

    idx_t   rd_addr;
    entry_t rd_entry;
    logic   wr_en;
    entry_t wr_entry;
    qctl_t  qctl;
    qstat_t qstat;
    mask_t  req_mask;
    gen_t   gen_inc;

    gea_slot_store u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_addr    (rd_addr),
        .rd_data    (rd_entry),
        .wr_en      (wr_en),
        .wr_addr    (slot_reg),
        .wr_data    (wr_entry),
        .clear_done (clear_done)
    );

    gea_recycle_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (qctl),
        .stat    (qstat)
    );

    assign s_ready  = (state_reg == ST_IDLE) && clear_done;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign commit   = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    assign req_mask = MASK_BITS'(req_reg.component_mask);
    assign gen_inc  = rd_entry.gen + gen_t'(1);

    // slot selection, in the cycle after transfer
    always_comb begin
        need_grow = (fresh_reg >= pool_reg) && (qstat.count == '0);
        exhausted = need_grow && (pool_reg >= pool_t'(SLOTS));
        grown     = (pool_reg >= pool_t'(SLOTS / 2)) ? pool_t'(SLOTS) : (pool_reg << 1);
        pool_eff  = need_grow ? grown : pool_reg;
        use_fresh = (fresh_reg < pool_eff);
        oop       = (pool_t'(req_reg.slot_index) >= pool_reg);
        if (req_reg.req_type == REQ_CREATE) begin
            slot_sel = use_fresh ? fresh_reg[IDX_W-1:0] : qstat.head_data;
        end else begin
            slot_sel = req_reg.slot_index;
        end
    end

    assign rd_addr = (state_reg == ST_ADDR) ? slot_sel : slot_reg;

    // read-modify-write and response
    always_comb begin
        rsp            = '0;
        rsp.out_index  = slot_reg;
        wr_en          = 1'b0;
        wr_entry       = rd_entry;
        qctl           = '0;
        qctl.push_data = slot_reg;
        pool_next      = pool_reg;
        fresh_next     = fresh_reg;
        case (req_reg.req_type)
            REQ_CREATE: begin
                if (exhausted_reg) begin
                    rsp.out_index = '0;
                    rsp.status    = STAT_EXHAUSTED;
                end else begin
                    wr_en              = 1'b1;
                    wr_entry.mask      = req_mask;
                    rsp.out_generation = 32'(rd_entry.gen);
                    rsp.out_mask       = 32'(req_mask);
                    rsp.is_valid       = 1'b1;
                    rsp.is_alive       = req_mask[0];
                    pool_next          = pool_eff_reg;
                    if (use_fresh_reg) begin
                        fresh_next = fresh_reg + pool_t'(1);
                    end else begin
                        qctl.pop = 1'b1;
                    end
                end
            end
            REQ_DESTROY: begin
                if (oop_reg) begin
                    rsp.status = STAT_OOP;
                end else if (qstat.count >= pool_t'(SLOTS)) begin
                    rsp.out_generation = 32'(rd_entry.gen);
                    rsp.out_mask       = 32'(rd_entry.mask);
                    rsp.status         = STAT_OVERFLOW;
                end else begin
                    wr_en              = 1'b1;
                    wr_entry.gen       = gen_inc;
                    wr_entry.mask      = '0;
                    qctl.push          = 1'b1;
                    rsp.out_generation = 32'(gen_inc);
                end
            end
            REQ_SETMASK: begin
                if (oop_reg) begin
                    rsp.status = STAT_OOP;
                end else begin
                    wr_en              = 1'b1;
                    wr_entry.mask      = req_mask;
                    rsp.out_generation = 32'(rd_entry.gen);
                    rsp.out_mask       = 32'(req_mask);
                end
            end
            default: begin
                if (!oop_reg) begin
                    rsp.out_generation = 32'(rd_entry.gen);
                    rsp.out_mask       = 32'(rd_entry.mask);
                    rsp.is_valid       = (rd_entry.gen == GEN_BITS'(req_reg.handle_generation));
                    rsp.is_alive       = rsp.is_valid && rd_entry.mask[0];
                end
            end
        endcase
        if (!commit) begin
            wr_en      = 1'b0;
            qctl.push  = 1'b0;
            qctl.pop   = 1'b0;
            pool_next  = pool_reg;
            fresh_next = fresh_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pool_reg    <= pool_t'(START_SLOTS);
            fresh_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pool_reg  <= pool_next;
            fresh_reg <= fresh_next;
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        if (state_reg == ST_ADDR) begin
            slot_reg      <= slot_sel;
            pool_eff_reg  <= pool_eff;
            exhausted_reg <= exhausted;
            use_fresh_reg <= use_fresh;
            oop_reg       <= oop;
        end
        if (commit) begin
            m_data_reg <= rsp;
        end
    end

    a_fresh_in_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_reg <= pool_reg)
        else $error("fresh counter beyond pool size");

    a_pool_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (pool_reg <= pool_t'(SLOTS)) && (pool_reg >= pool_t'(START_SLOTS)))
        else $error("pool size out of range");

    a_rsp_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("response without write-back step");

    a_no_accept_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        !clear_done |-> !s_ready)
        else $error("request taken during clearing pass");

endmodule

FILE: test/tb.sv
// Testbench for generational_entity_allocator: random and directed requests
// checked against an in-bench model of the slot pool. Depends on gea_pkg and
// the allocator RTL.
`timescale 1ns / 1ps

module tb;
    import gea_pkg::*;

    typedef struct packed {
        req_t r;
        logic drain;
    } backlog_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    generational_entity_allocator uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    // Pool model, two copies: 0 tracks the planned sequence, 1 the accepted one.
    gen_t gen_tbl [2][SLOTS];
    mask_t mask_tbl [2][SLOTS];
    idx_t recycle_fifo [2][SLOTS];
    int recycle_rd [2];
    int recycle_wr [2];
    int recycle_cnt [2];
    int fresh_nx [2];
    int pool_sz [2];

    backlog_t req_backlog [$];
    rsp_t rsp_due [$];
    rsp_t plan_rsp;

    int err_cnt = 0;
    int rsp_seen = 0;
    logic s_taken = 1'b0;
    logic hold = 1'b0;
    int gap_left = 0;
    int burst_left = 0;
    logic nxt_valid;
    req_t nxt_data;
    logic [15:0] rdy_pat = '1;
    logic [31:0] rdy_cyc = '0;

    function automatic void pool_reset(input int cp);
        for (int i = 0; i < SLOTS; i++) begin
            gen_tbl[cp][i] = (i < START_SLOTS) ? gen_t'(1) : gen_t'(0);
            mask_tbl[cp][i] = '0;
            recycle_fifo[cp][i] = '0;
        end
        recycle_rd[cp] = 0;
        recycle_wr[cp] = 0;
        recycle_cnt[cp] = 0;
        fresh_nx[cp] = 0;
        pool_sz[cp] = START_SLOTS;
    endfunction

    function automatic rsp_t alloc_response(input int cp, input req_t r);
        rsp_t o;
        idx_t slot;
        int grown;
        o = '0;
        slot = r.slot_index;
        if (r.req_type == REQ_CREATE) begin
            if (fresh_nx[cp] >= pool_sz[cp] && recycle_cnt[cp] == 0) begin
                if (pool_sz[cp] >= SLOTS) begin
                    o.status = STAT_EXHAUSTED;
                    return o;
                end
                grown = pool_sz[cp] * 2;
                pool_sz[cp] = (grown > SLOTS) ? SLOTS : grown;
            end
            if (fresh_nx[cp] < pool_sz[cp]) begin
                slot = idx_t'(fresh_nx[cp]);
                fresh_nx[cp]++;
            end else begin
                slot = recycle_fifo[cp][recycle_rd[cp]];
                recycle_rd[cp] = (recycle_rd[cp] + 1) % SLOTS;
                recycle_cnt[cp]--;
            end
            mask_tbl[cp][slot] = r.component_mask;
            o.out_index = slot;
            o.out_generation = gen_tbl[cp][slot];
            o.out_mask = r.component_mask;
            o.is_valid = 1'b1;
            o.is_alive = r.component_mask[0];
            o.status = STAT_OK;
            return o;
        end
        o.out_index = slot;
        if (int'(slot) >= pool_sz[cp]) begin
            o.status = (r.req_type == REQ_QUERY) ? STAT_OK : STAT_OOP;
            return o;
        end
        case (r.req_type)
            REQ_DESTROY: begin
                if (recycle_cnt[cp] >= SLOTS) begin
                    o.out_generation = gen_tbl[cp][slot];
                    o.out_mask = mask_tbl[cp][slot];
                    o.status = STAT_OVERFLOW;
                end else begin
                    mask_tbl[cp][slot] = '0;
                    gen_tbl[cp][slot] = gen_tbl[cp][slot] + 1'b1;
                    recycle_fifo[cp][recycle_wr[cp]] = slot;
                    recycle_wr[cp] = (recycle_wr[cp] + 1) % SLOTS;
                    recycle_cnt[cp]++;
                    o.out_generation = gen_tbl[cp][slot];
                end
            end
            REQ_SETMASK: begin
                mask_tbl[cp][slot] = r.component_mask;
                o.out_generation = gen_tbl[cp][slot];
                o.out_mask = r.component_mask;
            end
            default: begin
                o.out_generation = gen_tbl[cp][slot];
                o.out_mask = mask_tbl[cp][slot];
                o.is_valid = (gen_tbl[cp][slot] == r.handle_generation);
                o.is_alive = o.is_valid & mask_tbl[cp][slot][0];
            end
        endcase
        return o;
    endfunction

    task automatic plan(input logic [1:0] kind, input int idx, input logic [31:0] hgen,
                        input logic [31:0] mask, input logic drain);
        backlog_t b;
        b.r.req_type = kind;
        b.r.slot_index = idx_t'(idx);
        b.r.handle_generation = hgen;
        b.r.component_mask = mask;
        b.drain = drain;
        plan_rsp = alloc_response(0, b.r);
        req_backlog.insert(req_backlog.size(), b);
    endtask

    function automatic int pick_index();
        if (pool_sz[0] < SLOTS && $urandom_range(0, 9) == 0)
            return $urandom_range(pool_sz[0], SLOTS - 1);
        return $urandom_range(0, pool_sz[0] - 1);
    endfunction

    function automatic logic [31:0] pick_mask();
        case ($urandom_range(0, 7))
            0: return '1;
            1: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_hgen(input int idx);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return gen_tbl[0][idx];
        if (sel < 8) return gen_tbl[0][idx] - 1;
        return $urandom;
    endfunction

    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("%s", msg);
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // stimulus plan
    initial begin
        int idx, sel;
        pool_reset(0);
        pool_reset(1);

        plan(REQ_QUERY, 0, 32'd1, '1, 1'b0);
        plan(REQ_QUERY, 15, 32'd0, '0, 1'b0);
        plan(REQ_QUERY, 1023, '1, '1, 1'b0);
        plan(REQ_CREATE, 0, '0, '1, 1'b0);
        plan(REQ_CREATE, 1023, '1, '0, 1'b0);
        plan(REQ_CREATE, 0, '0, 32'd1, 1'b0);
        plan(REQ_SETMASK, 1, '0, 32'hFFFF_FFFE, 1'b0);
        plan(REQ_SETMASK, 1023, '1, '1, 1'b0);
        plan(REQ_DESTROY, 16, '0, '1, 1'b0);
        plan(REQ_DESTROY, 0, '0, '0, 1'b0);
        plan(REQ_DESTROY, 0, '1, '1, 1'b0);
        plan(REQ_QUERY, 0, 32'd3, '0, 1'b0);
        plan(REQ_QUERY, 0, 32'd2, '0, 1'b0);
        plan(REQ_QUERY, 2, '1, '0, 1'b0);
        plan(REQ_QUERY, 2, 32'd1, '0, 1'b0);
        plan(REQ_DESTROY, 15, '0, '0, 1'b0);
        plan(REQ_QUERY, 15, 32'd2, '0, 1'b0);
        plan(REQ_SETMASK, 15, '0, 32'd1, 1'b0);

        for (int i = 0; i < 750; i++) begin
            sel = $urandom_range(0, 99);
            idx = pick_index();
            if (sel < 35)
                plan(REQ_CREATE, $urandom_range(0, SLOTS - 1), $urandom, pick_mask(), i == 500);
            else if (sel < 55)
                plan(REQ_DESTROY, idx, $urandom, $urandom, i == 500);
            else if (sel < 70)
                plan(REQ_SETMASK, idx, $urandom, pick_mask(), i == 500);
            else
                plan(REQ_QUERY, idx, pick_hgen(idx), $urandom, i == 500);
        end

        for (int i = 0; i < 40; i++) begin
            plan(REQ_CREATE, 0, $urandom, pick_mask(), 1'b0);
            idx = plan_rsp.out_index;
            plan(REQ_QUERY, idx, pick_hgen(idx), $urandom, 1'b0);
        end
    end

    // reset and end of run
    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (req_backlog.size() != 0 || s_valid) @(posedge aclk);
        while (rsp_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("** generational_entity_allocator: PASSED **");
        end else begin
            $display("** generational_entity_allocator: FAILED **");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("** generational_entity_allocator: FAILED **");
        $finish;
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        while (rsp_seen < 200) @(posedge aclk);
        hold = 1'b1;
        repeat (300) @(posedge aclk);
        hold = 1'b0;
    end

    // request driver: bursts with gaps, optional drain before an item
    always @(negedge aclk) begin
        nxt_valid = s_valid;
        nxt_data = s_data;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_valid && s_taken) nxt_valid = 1'b0;
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (req_backlog.size() != 0 &&
                             !(req_backlog[0].drain && rsp_due.size() != 0)) begin
                    nxt_data = req_backlog.pop_front().r;
                    nxt_valid = 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        if ($urandom_range(0, 7) == 0) begin
                            burst_left = 80;
                            gap_left = 0;
                        end else begin
                            burst_left = $urandom_range(1, 24);
                            gap_left = $urandom_range(0, 6);
                        end
                    end
                end
            end
        end
        s_valid <= nxt_valid;
        s_data <= nxt_data;
    end

    // receiver stall pattern
    always @(negedge aclk) begin
        if (rdy_cyc[5:0] == 6'd0)
            rdy_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        m_ready <= aresetn && !hold && rdy_pat[rdy_cyc[3:0]];
        rdy_cyc = rdy_cyc + 1;
    end

    // monitor: predict on request transfer, check on response transfer
    always @(posedge aclk) begin
        rsp_t e;
        s_taken = s_valid && s_ready;
        if (aresetn && s_taken) rsp_due.insert(rsp_due.size(), alloc_response(1, s_data));
        if (aresetn && m_valid && m_ready) begin
            rsp_seen++;
            if (rsp_due.size() == 0) begin
                note_error($sformatf("unexpected response idx=%0d st=%0d",
                                     m_data.out_index, m_data.status));
            end else begin
                e = rsp_due.pop_front();
                if (m_data.out_index !== e.out_index ||
                    m_data.out_generation !== e.out_generation ||
                    m_data.out_mask !== e.out_mask ||
                    m_data.is_valid !== e.is_valid ||
                    m_data.is_alive !== e.is_alive ||
                    m_data.status !== e.status)
                    note_error($sformatf(
                        "mismatch exp idx=%0d gen=%h mask=%h v=%b a=%b st=%0d got idx=%0d gen=%h mask=%h v=%b a=%b st=%0d",
                        e.out_index, e.out_generation, e.out_mask, e.is_valid,
                        e.is_alive, e.status, m_data.out_index, m_data.out_generation,
                        m_data.out_mask, m_data.is_valid, m_data.is_alive,
                        m_data.status));
            end
        end
    end

endmodule
